/* rtl/prt_pkg.sv */
// prt_pkg: shared types and codes of the pending request table
// operation and status codes, entry layout, configuration and result words
// no dependencies
`default_nettype none

package prt_pkg;

	localparam logic [2:0] KIND_ADD   = 3'd0;
	localparam logic [2:0] KIND_SWEEP = 3'd1;
	localparam logic [2:0] KIND_RESP  = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_QUERY = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	localparam logic [7:0] FUNC_MASK = 8'h7F;

	localparam logic [31:0] TIMEOUT_RESET = 32'd3000;
	localparam logic [3:0]  RETRY_RESET   = 4'd3;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_RETRY   = 1'b1;

	typedef struct packed {
		logic [7:0]  node;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] qty;
		logic [31:0] stamp;
		logic [3:0]  retries;
	} entry_t;

	typedef struct packed {
		logic [31:0] timeout_ms;
		logic [3:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  node;
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] qty;
		logic [31:0] now_ms;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] retried;
		logic [4:0] removed;
		logic [4:0] pending;
		logic [3:0] slot;
	} res_t;

endpackage

`default_nettype wire

/* rtl/pending_request_table_top.sv */
// pending_request_table_top: an item is accepted only while the engine is idle and
// passes one read of the entry memory per slot, one compare stage and a finish state
// that writes a new entry and hands the result word on, waiting while the output is held
// the result word is registered in the output register as the finish state ends
// reset clears valid bits and pending count and loads timeout 3000 and retry limit 3;
// the entry memory is not cleared, only valid slots are ever used
`default_nettype none

module pending_request_table_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  node,
	input  wire logic [7:0]  func_code,
	input  wire logic [15:0] start_addr,
	input  wire logic [15:0] quantity,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [4:0]       retried_count,
	output logic [4:0]       removed_count,
	output logic [4:0]       pending_count,
	output logic [3:0]       match_slot
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EW = $bits(prt_pkg::entry_t);

	prt_pkg::cfg_t cfg_q;
	prt_pkg::cmd_t cmd;
	prt_pkg::res_t res;
	prt_pkg::res_t out_q;
	logic          res_valid;
	logic          res_ready;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_data;

	assign cmd.kind   = kind;
	assign cmd.node   = node;
	assign cmd.func   = func_code;
	assign cmd.addr   = start_addr;
	assign cmd.qty    = quantity;
	assign cmd.now_ms = now_ms;

	assign res_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms  <= prt_pkg::TIMEOUT_RESET;
			cfg_q.retry_limit <= prt_pkg::RETRY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				prt_pkg::CFG_TIMEOUT: cfg_q.timeout_ms  <= cfg_data;
				prt_pkg::CFG_RETRY:   cfg_q.retry_limit <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_ready) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign status        = out_q.status;
	assign retried_count = out_q.retried;
	assign removed_count = out_q.removed;
	assign pending_count = out_q.pending;
	assign match_slot    = out_q.slot;

	prt_engine #(
		.DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (in_valid),
		.cmd_ready (in_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	prt_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(EW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted word did not start a walk");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> out_valid)
		else $error("finished result not registered");

	a_no_read_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rd_en && !wr_en)
		else $error("memory access while idle");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == prt_pkg::ST_FULL |->
			retried_count == 5'd0 && removed_count == 5'd0 && match_slot == 4'd0)
		else $error("table full word carries counts or slot");
`endif

endmodule

`default_nettype wire

/* rtl/prt_ram.sv */
// prt_ram: single write port, single read port synchronous memory
// read data registered; no dependencies
`default_nettype none

module prt_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 84
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/prt_engine.sv */
// prt_engine: walks the entry memory once per operation, read-modify-write
// holds valid bits, pending count and the operation sequencer; uses prt_pkg
`default_nettype none

module prt_engine #(
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire prt_pkg::cfg_t                          cfg,
	input  wire logic                                   cmd_valid,
	output logic                                        cmd_ready,
	input  wire prt_pkg::cmd_t                          cmd,
	output logic                                        res_valid,
	input  wire logic                                   res_ready,
	output prt_pkg::res_t                               res,
	output logic                                        wr_en,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	output logic [$bits(prt_pkg::entry_t)-1:0]          wr_data,
	output logic                                        rd_en,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	input  wire logic [$bits(prt_pkg::entry_t)-1:0]     rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	state_t           state_q;
	prt_pkg::cmd_t    op_q;
	logic [DEPTH-1:0] valid_q;
	logic [CW-1:0]    pend_q;
	logic [CW-1:0]    rd_cnt_q;
	logic             chk_vld_s1;
	logic [AW-1:0]    chk_idx_s1;
	logic             found_q;
	logic [AW-1:0]    slot_q;
	logic             free_found_q;
	logic [AW-1:0]    free_q;
	logic [CW-1:0]    retried_q;
	logic [CW-1:0]    removed_q;

	prt_pkg::cmd_t   cmd_in;
	prt_pkg::entry_t ent;
	prt_pkg::entry_t sweep_ent;
	prt_pkg::entry_t add_ent;
	logic            ent_valid;
	logic            hit_all;
	logic            hit_node;
	logic [31:0]     elapsed;
	logic            timed_out;
	logic            may_retry;
	logic            is_full;
	logic            add_ok;
	logic            finish_go;
	logic            sweep_wr;
	logic [CW-1:0]   pend_next;

	assign ent       = prt_pkg::entry_t'(rd_data);
	assign ent_valid = valid_q[chk_idx_s1];
	assign hit_all   = ent_valid && ent.node == op_q.node && ent.func == op_q.func
		&& ent.addr == op_q.addr && ent.qty == op_q.qty;
	assign hit_node  = ent_valid && ent.node == op_q.node;
	assign elapsed   = op_q.now_ms - ent.stamp;
	assign timed_out = ent_valid && elapsed > cfg.timeout_ms;
	assign may_retry = ent.retries < cfg.retry_limit;
	assign is_full   = pend_q == CW'(DEPTH);
	assign add_ok    = op_q.kind == prt_pkg::KIND_ADD && !is_full && !found_q;
	assign finish_go = state_q == S_FINISH && res_ready;
	assign sweep_wr  = chk_vld_s1 && op_q.kind == prt_pkg::KIND_SWEEP && timed_out && may_retry;
	assign pend_next = CW'(pend_q + CW'(add_ok) - removed_q);

	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_FINISH;
	assign rd_en     = state_q == S_WALK && rd_cnt_q < CW'(DEPTH);
	assign rd_addr   = rd_cnt_q[AW-1:0];

	// responses match with the error flag dropped
	always_comb begin
		cmd_in = cmd;
		if (cmd.kind == prt_pkg::KIND_RESP) begin
			cmd_in.func = cmd.func & prt_pkg::FUNC_MASK;
		end
	end

	always_comb begin
		sweep_ent         = ent;
		sweep_ent.stamp   = op_q.now_ms;
		sweep_ent.retries = ent.retries + 4'd1;
		add_ent.node      = op_q.node;
		add_ent.func      = op_q.func;
		add_ent.addr      = op_q.addr;
		add_ent.qty       = op_q.qty;
		add_ent.stamp     = op_q.now_ms;
		add_ent.retries   = 4'd0;
		if (finish_go && add_ok) begin
			wr_en   = 1'b1;
			wr_addr = free_q;
			wr_data = add_ent;
		end else begin
			wr_en   = sweep_wr;
			wr_addr = chk_idx_s1;
			wr_data = sweep_ent;
		end
	end

	always_comb begin
		res.status  = prt_pkg::ST_DONE;
		res.retried = 5'd0;
		res.removed = 5'd0;
		res.pending = 5'(pend_next);
		res.slot    = 4'd0;
		case (op_q.kind)
			prt_pkg::KIND_ADD: begin
				if (is_full) begin
					res.status = prt_pkg::ST_FULL;
				end else if (found_q) begin
					res.status = prt_pkg::ST_DUP;
					res.slot   = 4'(slot_q);
				end else begin
					res.slot = 4'(free_q);
				end
			end
			prt_pkg::KIND_SWEEP: begin
				res.retried = 5'(retried_q);
				res.removed = 5'(removed_q);
			end
			prt_pkg::KIND_RESP: begin
				res.removed = 5'(removed_q);
				if (found_q) begin
					res.slot = 4'(slot_q);
				end else begin
					res.status = prt_pkg::ST_NOMATCH;
				end
			end
			prt_pkg::KIND_CLEAR: begin
				res.removed = 5'(removed_q);
			end
			prt_pkg::KIND_QUERY: begin
				if (found_q) begin
					res.slot = 4'(slot_q);
				end else begin
					res.status = prt_pkg::ST_NOMATCH;
				end
			end
			default: begin
				res.status = prt_pkg::ST_NOMATCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			pend_q       <= '0;
			rd_cnt_q     <= '0;
			chk_vld_s1   <= 1'b0;
			chk_idx_s1   <= '0;
			found_q      <= 1'b0;
			slot_q       <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			retried_q    <= '0;
			removed_q    <= '0;
			op_q         <= '0;
		end else begin
			chk_vld_s1 <= rd_en;
			chk_idx_s1 <= rd_addr;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q         <= cmd_in;
						state_q      <= S_WALK;
						rd_cnt_q     <= '0;
						found_q      <= 1'b0;
						slot_q       <= '0;
						free_found_q <= 1'b0;
						free_q       <= '0;
						retried_q    <= '0;
						removed_q    <= '0;
					end
				end
				S_WALK: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (chk_vld_s1) begin
						case (op_q.kind)
							prt_pkg::KIND_ADD: begin
								if (hit_all && !found_q) begin
									found_q <= 1'b1;
									slot_q  <= chk_idx_s1;
								end
								if (!ent_valid && !free_found_q) begin
									free_found_q <= 1'b1;
									free_q       <= chk_idx_s1;
								end
							end
							prt_pkg::KIND_SWEEP: begin
								if (timed_out) begin
									if (may_retry) begin
										retried_q <= retried_q + CW'(1);
									end else begin
										valid_q[chk_idx_s1] <= 1'b0;
										removed_q           <= removed_q + CW'(1);
									end
								end
							end
							prt_pkg::KIND_RESP: begin
								if (hit_all && !found_q) begin
									found_q             <= 1'b1;
									slot_q              <= chk_idx_s1;
									valid_q[chk_idx_s1] <= 1'b0;
									removed_q           <= CW'(1);
								end
							end
							prt_pkg::KIND_CLEAR: begin
								if (hit_node) begin
									valid_q[chk_idx_s1] <= 1'b0;
									removed_q           <= removed_q + CW'(1);
								end
							end
							prt_pkg::KIND_QUERY: begin
								if (hit_node && !found_q) begin
									found_q <= 1'b1;
									slot_q  <= chk_idx_s1;
								end
							end
							default: begin
							end
						endcase
						if (chk_idx_s1 == AW'(DEPTH - 1)) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (res_ready) begin
						if (add_ok) begin
							valid_q[free_q] <= 1'b1;
						end
						pend_q  <= pend_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
